// ===== rtl/hnds_pkg.sv =====
// shared types, constants and helpers for the near-duplicate key search unit
package hnds_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ID_W     = 10;
   localparam int MATCH_W  = 11;
   localparam int TOTAL_W  = 32;
   localparam int HALF_W   = 64;
   localparam int KEY_W    = 128;
   localparam int SEG_W    = 32;
   localparam int SEG_N    = KEY_W / SEG_W;
   localparam int SPOP_W   = $clog2(SEG_W + 1);
   localparam int DIST_W   = 8;
   localparam int RAD_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [RAD_W-1:0] RADIUS_MAX = RAD_W'(2);
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(8);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [1:0] RSP_INSERTED = 2'd0;
   localparam logic [1:0] RSP_CLASH    = 2'd1;
   localparam logic [1:0] RSP_FULL     = 2'd2;
   localparam logic [1:0] RSP_QUERY    = 2'd3;

   localparam logic CSR_IDX_MAX_DIST = 1'b0;
   localparam logic CSR_IDX_RADIUS   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } hnds_state_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic finish;
   } hnds_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic busy;
   } hnds_status_type;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [SPOP_W-1:0] pop32(input logic [SEG_W-1:0] v);
      return SPOP_W'(pop8(v[7:0])) + SPOP_W'(pop8(v[15:8]))
           + SPOP_W'(pop8(v[23:16])) + SPOP_W'(pop8(v[31:24]));
   endfunction

endpackage

// ===== rtl/hamming_near_duplicate_search_unit.sv =====
// top level of the near-duplicate key search unit with its register port
//
//   channel  | handshake           | payload
//   req      | req_valid/req_stall | req_operation, req_key_low, req_key_high
//   rsp      | rsp_valid/rsp_stall | rsp_status, rsp_assigned_id, rsp_match_count,
//            |                     | rsp_total_matches
//   csr      | csr_psel/csr_penable| csr_pwrite, csr_paddr, csr_pwdata, csr_prdata
//
// an insert or query is accepted, then one stored key is read per cycle from the
// single-port key memory, then the compare pipeline drains and the result is posted
// one transaction is worked at a time; a new one is taken while the result waits
// reset is synchronous and clears the stored key count and the running total
// a stalled result holds the block in its finish state until it is taken
module hamming_near_duplicate_search_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [hnds_pkg::HALF_W-1:0]   req_key_low,
   input  logic [hnds_pkg::HALF_W-1:0]   req_key_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [hnds_pkg::ID_W-1:0]     rsp_assigned_id,
   output logic [hnds_pkg::MATCH_W-1:0]  rsp_match_count,
   output logic [hnds_pkg::TOTAL_W-1:0]  rsp_total_matches,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hnds_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [hnds_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [hnds_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import hnds_pkg::*;

   hnds_cmd_type    cmd;
   hnds_status_type sts;

   logic [DIST_W-1:0] max_distance_ff, max_distance_in;
   logic [RAD_W-1:0]  search_radius_ff, search_radius_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff  <= MAX_DIST_RESET;
         search_radius_ff <= RADIUS_MAX;
      end else begin
         max_distance_ff  <= max_distance_in;
         search_radius_ff <= search_radius_in;
      end
   end

   always_comb begin
      max_distance_in  = max_distance_ff;
      search_radius_in = search_radius_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_MAX_DIST: max_distance_in  = csr_pwdata[DIST_W-1:0];
            CSR_IDX_RADIUS:   search_radius_in = csr_pwdata[RAD_W-1:0];
            default:          max_distance_in  = max_distance_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_MAX_DIST: csr_prdata = CSR_DW'(max_distance_ff);
         CSR_IDX_RADIUS:   csr_prdata = CSR_DW'(search_radius_ff);
         default:          csr_prdata = '0;
      endcase
   end

   hnds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hnds_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_key_low       (req_key_low),
      .req_key_high      (req_key_high),
      .max_distance      (max_distance_ff),
      .search_radius     (search_radius_ff),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_match_count   (rsp_match_count),
      .rsp_total_matches (rsp_total_matches)
   );

endmodule

// ===== rtl/hnds_ctrl.sv =====
// sequencing state machine: accept, scan stored keys, drain, post result
module hnds_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  hnds_pkg::hnds_status_type sts,
   output hnds_pkg::hnds_cmd_type    cmd
);
   import hnds_pkg::*;

   hnds_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.scan_end) begin
               cmd.rd = 1'b1;
            end else if (!sts.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/hnds_datapath.sv =====
// key store, segment compare pipeline, counters and result registers
module hnds_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  hnds_pkg::hnds_cmd_type         cmd,
   output hnds_pkg::hnds_status_type      sts,
   input  logic                           req_operation,
   input  logic [hnds_pkg::HALF_W-1:0]    req_key_low,
   input  logic [hnds_pkg::HALF_W-1:0]    req_key_high,
   input  logic [hnds_pkg::DIST_W-1:0]    max_distance,
   input  logic [hnds_pkg::RAD_W-1:0]     search_radius,
   output logic [1:0]                     rsp_status,
   output logic [hnds_pkg::ID_W-1:0]      rsp_assigned_id,
   output logic [hnds_pkg::MATCH_W-1:0]   rsp_match_count,
   output logic [hnds_pkg::TOTAL_W-1:0]   rsp_total_matches
);
   import hnds_pkg::*;

   logic [KEY_W-1:0]   mem [CAPACITY];

   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               clash_ff, clash_in;
   logic               v1_ff, v2_ff;
   logic [KEY_W-1:0]   rdata_ff;
   logic [SPOP_W-1:0]  segpop_ff [SEG_N];
   logic [SPOP_W-1:0]  segpop_in [SEG_N];

   logic [1:0]         status_ff, status_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [MATCH_W-1:0] match_ff, match_in;

   logic [KEY_W-1:0]   diff;
   logic [RAD_W-1:0]   radius_sat;
   logic [DIST_W-1:0]  full_dist;
   logic               cand;
   logic               seg_eq;
   logic               do_write;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= {req_key_high, req_key_low};
      end
      if (cmd.rd) begin
         rdata_ff <= mem[addr_ff[ADDR_W-1:0]];
      end
      if (do_write) begin
         mem[entry_count_ff[ADDR_W-1:0]] <= key_ff;
      end
      for (int s = 0; s < SEG_N; s++) begin
         segpop_ff[s] <= segpop_in[s];
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         id_ff     <= id_in;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff        <= '0;
         entry_count_ff <= '0;
         total_ff       <= '0;
         count_ff       <= '0;
         clash_ff       <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
      end else begin
         addr_ff        <= addr_in;
         entry_count_ff <= entry_count_in;
         total_ff       <= total_in;
         count_ff       <= count_in;
         clash_ff       <= clash_in;
         v1_ff          <= cmd.rd;
         v2_ff          <= v1_ff;
      end
   end

   // compare stage: per-segment differing bit counts
   always_comb begin
      diff = key_ff ^ rdata_ff;
      for (int s = 0; s < SEG_N; s++) begin
         segpop_in[s] = pop32(diff[s*SEG_W +: SEG_W]);
      end
   end

   // score stage: candidate test, full distance, clash detect
   always_comb begin
      radius_sat = (search_radius > RADIUS_MAX) ? RADIUS_MAX : search_radius;
      cand      = 1'b0;
      seg_eq    = 1'b0;
      full_dist = '0;
      for (int s = 0; s < SEG_N; s++) begin
         if (segpop_ff[s] <= SPOP_W'(radius_sat)) begin
            cand = 1'b1;
         end
         if (segpop_ff[s] == '0) begin
            seg_eq = 1'b1;
         end
         full_dist = full_dist + DIST_W'(segpop_ff[s]);
      end
   end

   always_comb begin
      addr_in        = addr_ff;
      count_in       = count_ff;
      clash_in       = clash_ff;
      entry_count_in = entry_count_ff;
      total_in       = total_ff;
      status_in      = RSP_QUERY;
      id_in          = '0;
      match_in       = '0;
      do_write       = 1'b0;

      if (cmd.load) begin
         addr_in  = '0;
         count_in = '0;
         clash_in = 1'b0;
      end
      if (cmd.rd) begin
         addr_in = addr_ff + CNT_W'(1);
      end
      if (v2_ff) begin
         if (seg_eq) begin
            clash_in = 1'b1;
         end
         if (cand && (full_dist <= max_distance)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (op_ff == OP_INSERT) begin
         if (clash_ff) begin
            status_in = RSP_CLASH;
         end else if (entry_count_ff >= CNT_W'(CAPACITY)) begin
            status_in = RSP_FULL;
         end else begin
            status_in = RSP_INSERTED;
            id_in     = ID_W'(entry_count_ff);
            if (cmd.finish) begin
               do_write       = 1'b1;
               entry_count_in = entry_count_ff + CNT_W'(1);
            end
         end
      end else begin
         status_in = RSP_QUERY;
         match_in  = MATCH_W'(count_ff);
         if (cmd.finish) begin
            total_in = total_ff + TOTAL_W'(count_ff);
         end
      end
   end

   assign sts.scan_end = (addr_ff == entry_count_ff);
   assign sts.busy     = v1_ff | v2_ff;

   assign rsp_status        = status_ff;
   assign rsp_assigned_id   = id_ff;
   assign rsp_match_count   = match_ff;
   assign rsp_total_matches = total_ff;

endmodule

// ===== rtl/hnds_checker.sv =====
// port-level checks for the near-duplicate key search unit and its bind
module hnds_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_status,
   input logic [hnds_pkg::ID_W-1:0]     rsp_assigned_id,
   input logic [hnds_pkg::MATCH_W-1:0]  rsp_match_count,
   input logic [hnds_pkg::TOTAL_W-1:0]  rsp_total_matches
);
   import hnds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_total_matches))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in progress");

   a_insert_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != RSP_QUERY) |-> rsp_match_count == '0)
      else $error("insert result carries a match count");

   a_id_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != RSP_INSERTED) |-> rsp_assigned_id == '0)
      else $error("id given without a successful insert");

endmodule

bind hamming_near_duplicate_search_unit hnds_checker u_hnds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_assigned_id   (rsp_assigned_id),
   .rsp_match_count   (rsp_match_count),
   .rsp_total_matches (rsp_total_matches)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the near-duplicate key search unit
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hnds_pkg::*;

   localparam longint CYCLE_LIMIT = 64'd8_000_000;
   localparam logic [CSR_AW-1:0] MAX_DIST_ADDR = CSR_AW'(4 * int'(CSR_IDX_MAX_DIST));
   localparam logic [CSR_AW-1:0] RADIUS_ADDR   = CSR_AW'(4 * int'(CSR_IDX_RADIUS));

   typedef struct packed {
      logic [1:0]         status;
      logic [ID_W-1:0]    assigned_id;
      logic [MATCH_W-1:0] match_count;
      logic [TOTAL_W-1:0] total_matches;
   } search_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = OP_INSERT;
   logic [HALF_W-1:0]   req_key_low = '0;
   logic [HALF_W-1:0]   req_key_high = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [ID_W-1:0]     rsp_assigned_id;
   logic [MATCH_W-1:0]  rsp_match_count;
   logic [TOTAL_W-1:0]  rsp_total_matches;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor state
   logic [HALF_W-1:0]   key_store_low [CAPACITY];
   logic [HALF_W-1:0]   key_store_high [CAPACITY];
   int                  keys_held = 0;
   logic [TOTAL_W-1:0]  match_sum = '0;
   logic [DIST_W-1:0]   cfg_max_distance = MAX_DIST_RESET;
   logic [RAD_W-1:0]    cfg_radius = RADIUS_MAX;

   search_result_type   pending_results[$];
   search_result_type   oldest_result;
   int                  stall_left = 0;
   bit                  no_idle = 1'b0;
   int                  mismatches = 0;
   longint              cycles = 0;
   int                  inserted_seen = 0;
   int                  clash_seen = 0;
   int                  full_seen = 0;
   int                  query_seen = 0;
   int                  hit_queries = 0;
   int                  settings_applied = 0;

   hamming_near_duplicate_search_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key_low       (req_key_low),
      .req_key_high      (req_key_high),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_match_count   (rsp_match_count),
      .rsp_total_matches (rsp_total_matches),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   function automatic search_result_type predict_search_result(input logic op,
                                                             input logic [KEY_W-1:0] key);
      search_result_type r;
      logic [KEY_W-1:0] held;
      bit clash;
      bit cand;
      int n;
      int rad;
      r = '0;
      if (op == OP_INSERT) begin
         clash = 1'b0;
         for (int i = 0; i < keys_held; i++) begin
            held = {key_store_high[i], key_store_low[i]};
            for (int s = 0; s < SEG_N; s++) begin
               if (key[s*SEG_W +: SEG_W] == held[s*SEG_W +: SEG_W]) clash = 1'b1;
            end
         end
         if (clash) begin
            r.status = RSP_CLASH;
         end else if (keys_held >= CAPACITY) begin
            r.status = RSP_FULL;
         end else begin
            key_store_low[keys_held] = key[HALF_W-1:0];
            key_store_high[keys_held] = key[KEY_W-1:HALF_W];
            r.status = RSP_INSERTED;
            r.assigned_id = ID_W'(keys_held);
            keys_held++;
         end
      end else begin
         // radius three behaves as two
         rad = (int'(cfg_radius) > 2) ? 2 : int'(cfg_radius);
         n = 0;
         for (int i = 0; i < keys_held; i++) begin
            held = {key_store_high[i], key_store_low[i]};
            cand = 1'b0;
            for (int s = 0; s < SEG_N; s++) begin
               if ($countones(key[s*SEG_W +: SEG_W] ^ held[s*SEG_W +: SEG_W]) <= rad)
                  cand = 1'b1;
            end
            if (cand && ($countones(key ^ held) <= int'(cfg_max_distance))) n++;
         end
         match_sum = match_sum + TOTAL_W'(n);
         r.status = RSP_QUERY;
         r.match_count = MATCH_W'(n);
      end
      r.total_matches = match_sum;
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] toggle_bits(input logic [KEY_W-1:0] key,
                                                    input int first, input int span,
                                                    input int count);
      int pos;
      for (int i = 0; i < count; i++) begin
         pos = first + $urandom_range(0, span - 1);
         key[pos] = ~key[pos];
      end
      return key;
   endfunction

   // result side: check every accepted transaction, stall a random count per result
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (!rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, status %0d", $time, rsp_status);
            end else begin
               oldest_result = pending_results.pop_front();
               check_field("status", 64'(oldest_result.status), 64'(rsp_status));
               check_field("assigned_id", 64'(oldest_result.assigned_id),
                           64'(rsp_assigned_id));
               check_field("match_count", 64'(oldest_result.match_count),
                           64'(rsp_match_count));
               check_field("total_matches", 64'(oldest_result.total_matches),
                           64'(rsp_total_matches));
               case (oldest_result.status)
                  RSP_INSERTED: inserted_seen++;
                  RSP_CLASH:    clash_seen++;
                  RSP_FULL:     full_seen++;
                  default: begin
                     query_seen++;
                     if (oldest_result.match_count != 0) hit_queries++;
                  end
               endcase
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 5);
         end else if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_left != 0);
   end

   task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
      int gap;
      search_result_type expected;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_key_low = key[HALF_W-1:0];
      req_key_high = key[KEY_W-1:HALF_W];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected = predict_search_result(op, key);
      pending_results = {pending_results, expected};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == MAX_DIST_ADDR) cfg_max_distance = data[DIST_W-1:0];
      else cfg_radius = data[RAD_W-1:0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_AW-1:0] addr, output logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = addr;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic check_registers();
      logic [CSR_DW-1:0] readback;
      csr_read(MAX_DIST_ADDR, readback);
      check_field("max_distance readback", 64'(cfg_max_distance), 64'(readback[DIST_W-1:0]));
      csr_read(RADIUS_ADDR, readback);
      check_field("search_radius readback", 64'(cfg_radius), 64'(readback[RAD_W-1:0]));
   endtask

   task automatic apply_setting(input int max_dist, input int radius);
      wait_idle();
      csr_write(MAX_DIST_ADDR, CSR_DW'(max_dist));
      csr_write(RADIUS_ADDR, CSR_DW'(radius));
      check_registers();
      settings_applied++;
   endtask

   task automatic test_register_defaults();
      check_registers();
   endtask

   task automatic test_directed_basics();
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] bit_mask;
      base = {64'h89abcdef_fedcba98, 64'h13579bdf_2468ace0};
      send_request(OP_QUERY, '1);
      send_request(OP_INSERT, '0);
      send_request(OP_INSERT, '1);
      send_request(OP_INSERT, '0);
      // only segment zero equals a stored key
      send_request(OP_INSERT, {64'h3c3c3c3c_a5a5a5a5, 64'h5a5a5a5a_ffffffff});
      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, {64'h00000001_00000001, 64'h00000001_00000001});
      send_request(OP_QUERY, {64'h00000007_00000007, 64'h00000007_00000007});
      // candidate through segment zero but too far in total
      send_request(OP_QUERY, {64'h0f000000_000000f0, 64'h0000ff00_00000003});
      // a family of near keys with no equal segment
      send_request(OP_INSERT, base);
      for (int j = 0; j < 3; j++) begin
         bit_mask = {SEG_N{SEG_W'(1) << j}};
         send_request(OP_INSERT, base ^ bit_mask);
      end
      send_request(OP_QUERY, base);
      send_request(OP_QUERY, base ^ {SEG_N{SEG_W'(1)}});
      send_request(OP_INSERT, base ^ {SEG_N{SEG_W'(1)}});
   endtask

   task automatic test_setting_extremes();
      logic [KEY_W-1:0] base;
      base = {64'h89abcdef_fedcba98, 64'h13579bdf_2468ace0};
      // radius zero needs an equal segment
      apply_setting(8, 0);
      send_request(OP_QUERY, {64'h00000001_00000001, 64'h00000001_00000000});
      send_request(OP_QUERY, {64'h00000001_00000001, 64'h00000001_00000001});
      // radius three acts as two
      apply_setting(255, 3);
      send_request(OP_QUERY, {64'h00000007_00000007, 64'h00000007_00000007});
      send_request(OP_QUERY, {64'h00000003_00000003, 64'h00000003_00000003});
      apply_setting(255, 2);
      send_request(OP_QUERY, {64'hffffffff_ffffffff, 64'hffffffff_00000000});
      apply_setting(0, 1);
      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, base);
      apply_setting(128, 2);
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, ~base);
   endtask

   task automatic send_random_request();
      int kind;
      int idx;
      int s;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] held;
      kind = $urandom_range(0, 99);
      key = {$urandom, $urandom, $urandom, $urandom};
      held = key;
      if (keys_held != 0) begin
         idx = $urandom_range(0, keys_held - 1);
         held = {key_store_high[idx], key_store_low[idx]};
      end
      if (kind < 10) begin
         send_request(OP_INSERT, key);
      end else if (kind < 20) begin
         key = held;
         for (s = 0; s < SEG_N; s++) key = toggle_bits(key, s*SEG_W, SEG_W, $urandom_range(1, 2));
         send_request(OP_INSERT, key);
      end else if (kind < 25) begin
         s = $urandom_range(0, SEG_N - 1);
         key[s*SEG_W +: SEG_W] = held[s*SEG_W +: SEG_W];
         send_request(OP_INSERT, key);
      end else if (kind < 30) begin
         send_request(OP_INSERT, held);
      end else if (kind < 60) begin
         key = held;
         for (s = 0; s < SEG_N; s++) key = toggle_bits(key, s*SEG_W, SEG_W, $urandom_range(0, 3));
         send_request(OP_QUERY, key);
      end else if (kind < 80) begin
         send_request(OP_QUERY, toggle_bits(held, 0, KEY_W, $urandom_range(0, 16)));
      end else if (kind < 90) begin
         send_request(OP_QUERY, held);
      end else begin
         send_request(OP_QUERY, key);
      end
   endtask

   task automatic test_random_settings();
      int max_list[8];
      int radius_list[8];
      max_list = '{8, 0, 128, 255, 3, 12, 200, 16};
      radius_list = '{2, 1, 2, 3, 0, 1, 2, 2};
      for (int p = 0; p < 8; p++) begin
         apply_setting(max_list[p], radius_list[p]);
         no_idle = (p == 4);
         repeat (66) send_random_request();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_probe_family();
      logic [KEY_W-1:0] probe;
      logic [KEY_W-1:0] key;
      logic [SEG_W-1:0] flip_mask;
      int s;
      apply_setting(255, 2);
      probe = {$urandom, $urandom, $urandom, $urandom};
      // each family key sits two bits from the probe in one segment
      for (int f = 0; f < 16; f++) begin
         key = {$urandom, $urandom, $urandom, $urandom};
         s = f % SEG_N;
         flip_mask = (SEG_W'(1) << f) | (SEG_W'(1) << (16 + f));
         key[s*SEG_W +: SEG_W] = probe[s*SEG_W +: SEG_W] ^ flip_mask;
         send_request(OP_INSERT, key);
      end
      // lowest segment equal to the newest stored key
      key = {$urandom, $urandom, $urandom, $urandom};
      key[SEG_W-1:0] = key_store_low[keys_held-1][SEG_W-1:0];
      send_request(OP_INSERT, key);
      send_request(OP_QUERY, probe);
      apply_setting(255, 1);
      send_request(OP_QUERY, probe);
      apply_setting(0, 2);
      send_request(OP_QUERY, {key_store_high[keys_held-1], key_store_low[keys_held-1]});
      apply_setting(40, 2);
      repeat (4) send_random_request();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_register_defaults();
      test_directed_basics();
      test_setting_extremes();
      test_random_settings();
      test_probe_family();
      wait_idle();
      repeat (CAPACITY + 8) @(posedge clock);
      $display("covered %0d inserts, %0d clash and %0d full rejects, %0d queries (%0d hit)",
               inserted_seen, clash_seen, full_seen, query_seen, hit_queries);
      $display("over %0d register settings with random handshake gaps", settings_applied);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
